>>> hdl/trickle_timer_assert.svh
// ---------------------------------------------------------------------------
// Trickle timer assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef TRICKLE_TIMER_ASSERT_SVH
`define TRICKLE_TIMER_ASSERT_SVH

// Same-cycle implication.
`define TT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tt_pkg.sv
// ---------------------------------------------------------------------------
// Trickle timer package
// Widths, command and register codes, reset values and payload types.
// ---------------------------------------------------------------------------
package tt_pkg;

  localparam int CMD_W   = 2;
  localparam int FRAC_W  = 16;
  localparam int LEN_W   = 32;
  localparam int MIN_W   = 16;
  localparam int DBL_W   = 5;
  localparam int HEARD_W = 8;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 16;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HEARD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_MIN_INTERVAL  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MAX_DOUBLINGS = 2'd1;
  localparam logic [CIDX_W-1:0] REG_REDUNDANCY    = 2'd2;

  // Register reset values
  localparam logic [MIN_W-1:0]   MIN_INTERVAL_RST  = 16'd8;
  localparam logic [DBL_W-1:0]   MAX_DOUBLINGS_RST = 5'd16;
  localparam logic [HEARD_W-1:0] REDUNDANCY_RST    = 8'd10;

  // Shortest interval the timer runs with
  localparam logic [MIN_W-1:0] MIN_INTERVAL_FLOOR = 16'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [FRAC_W-1:0] random_fraction;
  } in_item_t;

  typedef struct packed {
    logic               transmit;
    logic               suppressed;
    logic               interval_started;
    logic [LEN_W-1:0]   interval_ticks;
    logic [HEARD_W-1:0] heard_now;
  } out_item_t;

endpackage

>>> hdl/tt_if.sv
// ---------------------------------------------------------------------------
// Trickle timer channels
// Valid/ready channels for commands in and timer results out.
// ---------------------------------------------------------------------------
interface tt_in_if;
  logic                      valid;
  logic                      ready;
  logic [tt_pkg::CMD_W-1:0]  command;
  logic [tt_pkg::FRAC_W-1:0] random_fraction;

  modport source (output valid, output command, output random_fraction, input ready);
  modport sink   (input valid, input command, input random_fraction, output ready);
endinterface

interface tt_out_if;
  logic                       valid;
  logic                       ready;
  logic                       transmit;
  logic                       suppressed;
  logic                       interval_started;
  logic [tt_pkg::LEN_W-1:0]   interval_ticks;
  logic [tt_pkg::HEARD_W-1:0] heard_now;

  modport source (output valid, output transmit, output suppressed,
                  output interval_started, output interval_ticks,
                  output heard_now, input ready);
  modport sink   (input valid, input transmit, input suppressed,
                  input interval_started, input interval_ticks,
                  input heard_now, output ready);
endinterface

>>> hdl/trickle_timer.sv
// ---------------------------------------------------------------------------
// Trickle timer
// Tick-counted trickle timer: interval doubling, fire point, suppression.
// ---------------------------------------------------------------------------
// Usage:
//   in_chan  : one command per transfer (tick, consistent message heard,
//              start/restart) plus a 16-bit random fraction used whenever
//              a new interval begins.
//   out_chan : exactly one result per command: transmit / suppressed flags,
//              interval-started flag, current interval length, heard count.
//   cfg_*    : write-only registers (min_interval, max_doublings,
//              redundancy); write only while no command is in flight.
// Timing: one command per cycle sustained while out_chan.ready stays high.
//   A command taken is held in the input register, evaluated against the
//   timer state and loaded into the output register, from which its result
//   is offered on out_chan. The per-command path is one 32x16 multiply for
//   the new fire point plus a 32-bit add and compares.
// Reset: timer stopped, all counters zero, registers at defaults; no
//   results pending. Ticks before the first start change nothing.
// Stall: when out_chan.ready is low the output register holds, the input
//   register fills, then in_chan.ready drops; nothing is dropped.
// ---------------------------------------------------------------------------
`include "trickle_timer_assert.svh"

module trickle_timer (
  input  logic                        clk,
  input  logic                        rst_n,
  tt_in_if.sink                       in_chan,
  tt_out_if.source                    out_chan,
  input  logic                        cfg_we,
  input  logic [tt_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [tt_pkg::CDATA_W-1:0]  cfg_wdata
);

  localparam int LW = tt_pkg::LEN_W;
  localparam int PW = tt_pkg::LEN_W + tt_pkg::FRAC_W;

  // Configuration registers
  logic [tt_pkg::MIN_W-1:0]   min_interval_r;
  logic [tt_pkg::DBL_W-1:0]   max_doublings_r;
  logic [tt_pkg::HEARD_W-1:0] redundancy_r;

  // Timer state
  logic                       running_r, running_nxt;
  logic [LW-1:0]              interval_len_r, interval_len_nxt;
  logic [tt_pkg::DBL_W-1:0]   doublings_r, doublings_nxt;
  logic [LW-1:0]              elapsed_r, elapsed_nxt;
  logic [LW-1:0]              fire_point_r, fire_point_nxt;
  logic [tt_pkg::HEARD_W-1:0] heard_r, heard_nxt;

  // Input register
  logic                       in_valid_r;
  tt_pkg::in_item_t           in_item_r;

  // Output register
  logic                       out_valid_r;
  tt_pkg::out_item_t          out_item_r, out_item_nxt;

  logic                       advance;
  logic                       draw;
  logic [LW-1:0]              elapsed_inc;
  logic [LW-1:0]              half_len;
  logic [PW-1:0]              frac_prod;
  logic [LW-1:0]              fire_draw;

  // Process the held command whenever the output register is free or draining.
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;

  // ---------------------------------------------------------------------
  // Configuration writes; unknown index ignored
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r  <= tt_pkg::MIN_INTERVAL_RST;
      max_doublings_r <= tt_pkg::MAX_DOUBLINGS_RST;
      redundancy_r    <= tt_pkg::REDUNDANCY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tt_pkg::REG_MIN_INTERVAL:  min_interval_r  <= cfg_wdata;
        tt_pkg::REG_MAX_DOUBLINGS: max_doublings_r <= cfg_wdata[tt_pkg::DBL_W-1:0];
        tt_pkg::REG_REDUNDANCY:    redundancy_r    <= cfg_wdata[tt_pkg::HEARD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_item_r.command         <= in_chan.command;
      in_item_r.random_fraction <= in_chan.random_fraction;
    end
  end

  // ---------------------------------------------------------------------
  // Timer step
  // ---------------------------------------------------------------------
  assign elapsed_inc = elapsed_r + LW'(1);

  always_comb begin
    running_nxt      = running_r;
    interval_len_nxt = interval_len_r;
    doublings_nxt    = doublings_r;
    heard_nxt        = heard_r;
    elapsed_nxt      = elapsed_r;
    draw             = 1'b0;
    out_item_nxt     = '0;

    unique case (in_item_r.command)
      tt_pkg::CMD_START: begin
        interval_len_nxt = (min_interval_r < tt_pkg::MIN_INTERVAL_FLOOR)
                         ? LW'(tt_pkg::MIN_INTERVAL_FLOOR)
                         : LW'(min_interval_r);
        doublings_nxt    = '0;
        heard_nxt        = '0;
        running_nxt      = 1'b1;
        draw             = 1'b1;
        out_item_nxt.interval_started = 1'b1;
      end
      tt_pkg::CMD_HEARD: begin
        if (heard_r != '1) begin
          heard_nxt = heard_r + tt_pkg::HEARD_W'(1);
        end
      end
      tt_pkg::CMD_TICK: begin
        if (running_r) begin
          elapsed_nxt = elapsed_inc;
          // fire point decision uses the count heard so far this interval
          if (elapsed_inc == fire_point_r) begin
            if (heard_r <= redundancy_r) begin
              out_item_nxt.transmit = 1'b1;
            end else begin
              out_item_nxt.suppressed = 1'b1;
            end
          end
          if (elapsed_inc >= interval_len_r) begin
            if (doublings_r < max_doublings_r) begin
              // saturate rather than wrap on a very long interval
              interval_len_nxt = interval_len_r[LW-1] ? '1 : {interval_len_r[LW-2:0], 1'b0};
              doublings_nxt    = doublings_r + tt_pkg::DBL_W'(1);
            end
            heard_nxt = '0;
            draw      = 1'b1;
            out_item_nxt.interval_started = 1'b1;
          end
        end
      end
      default: ;
    endcase

    out_item_nxt.interval_ticks = interval_len_nxt;
    out_item_nxt.heard_now      = heard_nxt;
  end

  // New fire point in the second half: I/2 + (I/2 * r) / 2^16
  assign half_len  = interval_len_nxt >> 1;
  assign frac_prod = PW'(half_len) * PW'(in_item_r.random_fraction);
  assign fire_draw = half_len + frac_prod[PW-1:tt_pkg::FRAC_W];

  always_comb begin
    fire_point_nxt = fire_point_r;
    if (draw) begin
      fire_point_nxt = fire_draw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r      <= 1'b0;
      interval_len_r <= '0;
      doublings_r    <= '0;
      elapsed_r      <= '0;
      fire_point_r   <= '0;
      heard_r        <= '0;
    end else if (advance) begin
      running_r      <= running_nxt;
      interval_len_r <= interval_len_nxt;
      doublings_r    <= doublings_nxt;
      elapsed_r      <= draw ? '0 : elapsed_nxt;
      fire_point_r   <= fire_point_nxt;
      heard_r        <= heard_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.transmit         = out_item_r.transmit;
  assign out_chan.suppressed       = out_item_r.suppressed;
  assign out_chan.interval_started = out_item_r.interval_started;
  assign out_chan.interval_ticks   = out_item_r.interval_ticks;
  assign out_chan.heard_now        = out_item_r.heard_now;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `TT_ASSERT_NOW(a_tx_sup_excl, out_valid_r, !(out_item_r.transmit && out_item_r.suppressed), "transmit and suppressed both set")
  `TT_ASSERT_NOW(a_len_floor, running_r, interval_len_r >= LW'(tt_pkg::MIN_INTERVAL_FLOOR), "running interval below floor")
  `TT_ASSERT_NOW(a_fire_inside, running_r, (fire_point_r != '0) && (fire_point_r < interval_len_r), "fire point outside interval")
  `TT_ASSERT_NOW(a_elapsed_inside, running_r, elapsed_r < interval_len_r, "elapsed past interval end")
  `TT_ASSERT_NEXT(a_result_loaded, advance, out_valid_r, "processed command left no result")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Trickle timer testbench
// Drives commands into the timer over the valid/ready input channel, predicts
// each result with a cycle-free model of the timer, and checks every result
// transfer field by field in order. The run covers directed corner cases,
// heard-count saturation and random command streams under several
// sender/receiver idle mixes.
// ---------------------------------------------------------------------------
module tb_top;

  // Codes the package leaves out: spare command value, spare register index
  localparam logic [tt_pkg::CMD_W-1:0]  CMD_SPARE = 2'd3;
  localparam logic [tt_pkg::CIDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [tt_pkg::FRAC_W-1:0] FRAC_ALL_ONES = 16'hFFFF;
  localparam int SETTLE_CYCLES = 8;
  localparam int RESET_CYCLES  = 12;
  localparam int PROD_W  = tt_pkg::LEN_W + tt_pkg::FRAC_W;
  localparam int FIELD_W = tt_pkg::LEN_W;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  logic [tt_pkg::CIDX_W-1:0]   cfg_index;
  logic [tt_pkg::CDATA_W-1:0]  cfg_wdata;

  tt_in_if  in_ch ();
  tt_out_if out_ch ();

  trickle_timer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Watchdog. Ends a hung run as NOT OK; the slowest legal run is about 700
  // transfers, each with long sender gaps and receiver stalls.
  initial begin
    #10_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Timer predictor: own copy of registers and timer state
  // -------------------------------------------------------------------------
  logic [tt_pkg::MIN_W-1:0]   min_len;
  logic [tt_pkg::DBL_W-1:0]   dbl_limit;
  logic [tt_pkg::HEARD_W-1:0] heard_limit;

  logic                       tmr_running;
  logic [tt_pkg::LEN_W-1:0]   tmr_len;
  logic [tt_pkg::DBL_W-1:0]   tmr_doubled;
  logic [tt_pkg::LEN_W-1:0]   tmr_elapsed;
  logic [tt_pkg::LEN_W-1:0]   tmr_fire;
  logic [tt_pkg::HEARD_W-1:0] tmr_heard;

  tt_pkg::out_item_t expected_q[$];

  int errors   = 0;
  int n_sent   = 0;
  int n_tx     = 0;
  int n_sup    = 0;
  int n_new    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  function automatic void timer_clear();
    min_len     = tt_pkg::MIN_INTERVAL_RST;
    dbl_limit   = tt_pkg::MAX_DOUBLINGS_RST;
    heard_limit = tt_pkg::REDUNDANCY_RST;
    tmr_running = 1'b0;
    tmr_len     = '0;
    tmr_doubled = '0;
    tmr_elapsed = '0;
    tmr_fire    = '0;
    tmr_heard   = '0;
  endfunction

  // Fire point sits in the second half: half + half*frac/65536
  function automatic void draw_fire_point(input logic [tt_pkg::FRAC_W-1:0] frac);
    logic [tt_pkg::LEN_W-1:0] half;
    logic [PROD_W-1:0]        prod;
    half = tmr_len >> 1;
    prod = PROD_W'(half) * PROD_W'(frac);
    tmr_fire    = half + prod[PROD_W-1:tt_pkg::FRAC_W];
    tmr_elapsed = '0;
  endfunction

  function automatic tt_pkg::out_item_t timer_step(input logic [tt_pkg::CMD_W-1:0]  cmd,
                                                   input logic [tt_pkg::FRAC_W-1:0] frac);
    tt_pkg::out_item_t res;
    res = '0;
    case (cmd)
      tt_pkg::CMD_START: begin
        // minimum below the floor runs as the floor
        if (min_len < tt_pkg::MIN_INTERVAL_FLOOR) begin
          tmr_len = tt_pkg::LEN_W'(tt_pkg::MIN_INTERVAL_FLOOR);
        end else begin
          tmr_len = tt_pkg::LEN_W'(min_len);
        end
        tmr_doubled = '0;
        tmr_heard   = '0;
        tmr_running = 1'b1;
        draw_fire_point(frac);
        res.interval_started = 1'b1;
      end
      tt_pkg::CMD_HEARD: begin
        // counts while stopped too; saturates
        if (tmr_heard != {tt_pkg::HEARD_W{1'b1}}) tmr_heard = tmr_heard + 1'b1;
      end
      tt_pkg::CMD_TICK: begin
        if (tmr_running) begin
          tmr_elapsed = tmr_elapsed + 1'b1;
          if (tmr_elapsed == tmr_fire) begin
            if (tmr_heard <= heard_limit) res.transmit = 1'b1;
            else res.suppressed = 1'b1;
          end
          if (tmr_elapsed >= tmr_len) begin
            if (tmr_doubled < dbl_limit) begin
              if (tmr_len[tt_pkg::LEN_W-1]) tmr_len = {tt_pkg::LEN_W{1'b1}};
              else tmr_len = tmr_len << 1;
              tmr_doubled = tmr_doubled + 1'b1;
            end
            tmr_heard = '0;
            draw_fire_point(frac);
            res.interval_started = 1'b1;
          end
        end
      end
      default: ;  // spare command: no effect at all
    endcase
    res.interval_ticks = tmr_len;
    res.heard_now      = tmr_heard;
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Result side: random stall on ready, in-order check of every transfer
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ch.ready <= (int'($urandom_range(99)) >= recv_stall_pct);
  end

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    tt_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual tx=%0b sup=%0b",
                 $time, out_ch.transmit, out_ch.suppressed);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("transmit", FIELD_W'(want.transmit), FIELD_W'(out_ch.transmit));
        check_field("suppressed", FIELD_W'(want.suppressed), FIELD_W'(out_ch.suppressed));
        check_field("interval_started", FIELD_W'(want.interval_started),
                    FIELD_W'(out_ch.interval_started));
        check_field("interval_ticks", want.interval_ticks, out_ch.interval_ticks);
        check_field("heard_now", FIELD_W'(want.heard_now), FIELD_W'(out_ch.heard_now));
        n_tx  += int'(want.transmit);
        n_sup += int'(want.suppressed);
        n_new += int'(want.interval_started);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Command side. All tasks enter and leave on a falling edge.
  // -------------------------------------------------------------------------

  // One command transfer. Valid stays high on return so back-to-back
  // commands need no bubble; anything else must drop it first.
  task automatic send_cmd(input logic [tt_pkg::CMD_W-1:0]  cmd,
                          input logic [tt_pkg::FRAC_W-1:0] frac);
    bit lowered;
    lowered = 1'b0;
    while (int'($urandom_range(99)) < send_idle_pct) begin
      if (!lowered) begin
        in_ch.valid <= 1'b0;
        lowered = 1'b1;
      end
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.command         <= cmd;
    in_ch.random_fraction <= frac;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(timer_step(cmd, frac));
    n_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every result is back, then let the pipe settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write; only called with the timer drained
  task automatic write_reg(input logic [tt_pkg::CIDX_W-1:0]  idx,
                           input logic [tt_pkg::CDATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      tt_pkg::REG_MIN_INTERVAL:  min_len     = data;
      tt_pkg::REG_MAX_DOUBLINGS: dbl_limit   = data[tt_pkg::DBL_W-1:0];
      tt_pkg::REG_REDUNDANCY:    heard_limit = data[tt_pkg::HEARD_W-1:0];
      default: ;  // spare index is ignored
    endcase
  endtask

  function automatic logic [tt_pkg::FRAC_W-1:0] rand_frac();
    return tt_pkg::FRAC_W'($urandom_range(0, 65535));
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Out of reset the timer is stopped: ticks and the spare command do nothing,
  // heard still counts.
  task automatic test_stopped();
    send_cmd(tt_pkg::CMD_TICK, FRAC_ALL_ONES);
    send_cmd(CMD_SPARE, '0);
    send_cmd(tt_pkg::CMD_HEARD, 16'h1234);
    drain();
  endtask

  // Minimum of 0 or 1 runs as an interval of 2: fire on tick 1, end on tick 2
  task automatic test_small_min();
    write_reg(tt_pkg::REG_MIN_INTERVAL, 16'd0);
    send_cmd(tt_pkg::CMD_START, '0);
    send_cmd(tt_pkg::CMD_TICK, 16'h5A5A);
    send_cmd(tt_pkg::CMD_TICK, 16'hA5A5);
    drain();
    write_reg(tt_pkg::REG_MIN_INTERVAL, 16'd1);
    send_cmd(tt_pkg::CMD_START, FRAC_ALL_ONES);
    send_cmd(tt_pkg::CMD_TICK, '0);
    send_cmd(tt_pkg::CMD_TICK, FRAC_ALL_ONES);
    drain();
  endtask

  // Fraction extremes place the fire point at either end of the second half;
  // redundancy 0 suppresses after one heard, 255 always transmits.
  task automatic test_fire_extremes();
    write_reg(tt_pkg::REG_MIN_INTERVAL, 16'd4);
    write_reg(tt_pkg::REG_REDUNDANCY, 16'hFF00);  // upper bits must be dropped
    send_cmd(tt_pkg::CMD_START, FRAC_ALL_ONES);
    send_cmd(tt_pkg::CMD_HEARD, '0);
    repeat (4) send_cmd(tt_pkg::CMD_TICK, 16'h8000);
    drain();
    write_reg(tt_pkg::REG_REDUNDANCY, 16'h00FF);
    send_cmd(tt_pkg::CMD_START, '0);
    send_cmd(tt_pkg::CMD_HEARD, FRAC_ALL_ONES);
    repeat (2) send_cmd(tt_pkg::CMD_TICK, '0);
    drain();
    write_reg(tt_pkg::REG_MIN_INTERVAL, 16'hFFFF);
    send_cmd(tt_pkg::CMD_START, FRAC_ALL_ONES);
    send_cmd(tt_pkg::CMD_TICK, FRAC_ALL_ONES);
    drain();
  endtask

  // Doubling limit of 0 keeps the interval fixed; the widest limit and a
  // write to the spare index leave doubling unaffected.
  task automatic test_doubling_limit();
    write_reg(tt_pkg::REG_MIN_INTERVAL, 16'd2);
    write_reg(tt_pkg::REG_MAX_DOUBLINGS, 16'hFFE0);
    send_cmd(tt_pkg::CMD_START, 16'h0001);
    repeat (3) send_cmd(tt_pkg::CMD_TICK, 16'hFFFE);
    drain();
    write_reg(tt_pkg::REG_MAX_DOUBLINGS, 16'h001F);
    write_reg(REG_SPARE, 16'hFFFF);
    send_cmd(tt_pkg::CMD_START, 16'h8000);
    repeat (2) send_cmd(tt_pkg::CMD_TICK, 16'h7FFF);
    drain();
    write_reg(tt_pkg::REG_MAX_DOUBLINGS, 16'd16);
  endtask

  // Heard count pins at 255 and the fire point is suppressed; interval end
  // clears it.
  task automatic test_heard_saturation();
    write_reg(tt_pkg::REG_MIN_INTERVAL, 16'd16);
    write_reg(tt_pkg::REG_REDUNDANCY, 16'd10);
    send_cmd(tt_pkg::CMD_START, rand_frac());
    repeat (260) send_cmd(tt_pkg::CMD_HEARD, rand_frac());
    repeat (17) send_cmd(tt_pkg::CMD_TICK, rand_frac());
    drain();
  endtask

  task automatic random_config();
    logic [tt_pkg::CDATA_W-1:0] data;
    if ($urandom_range(5) == 0) begin
      case ($urandom_range(3))
        0: data = 16'd0;
        1: data = 16'd1;
        2: data = 16'd2;
        default: data = 16'hFFFF;
      endcase
    end else begin
      data = tt_pkg::CDATA_W'($urandom_range(2, 12));
    end
    write_reg(tt_pkg::REG_MIN_INTERVAL, data);

    // narrow registers get random junk above their width
    data = tt_pkg::CDATA_W'($urandom_range(0, 65535));
    if ($urandom_range(5) == 0) begin
      data[tt_pkg::DBL_W-1:0] = $urandom_range(1) ? 5'd16 : 5'd31;
    end else begin
      data[tt_pkg::DBL_W-1:0] = tt_pkg::DBL_W'($urandom_range(0, 5));
    end
    write_reg(tt_pkg::REG_MAX_DOUBLINGS, data);

    data = tt_pkg::CDATA_W'($urandom_range(0, 65535));
    case ($urandom_range(5))
      0:       data[tt_pkg::HEARD_W-1:0] = 8'd255;
      1:       data[tt_pkg::HEARD_W-1:0] = 8'd0;
      default: data[tt_pkg::HEARD_W-1:0] = tt_pkg::HEARD_W'($urandom_range(0, 4));
    endcase
    write_reg(tt_pkg::REG_REDUNDANCY, data);
  endtask

  // Mostly a start followed by ticks with scattered heard events, so the
  // timer walks through fire points and doublings; restarts and spare
  // commands sprinkled in.
  task automatic run_stream(input int count);
    logic [tt_pkg::CMD_W-1:0]  cmd;
    logic [tt_pkg::FRAC_W-1:0] frac;
    int                        roll;
    for (int i = 0; i < count; i++) begin
      roll = int'($urandom_range(99));
      if (i == 0 && roll < 85) cmd = tt_pkg::CMD_START;
      else if (roll < 76)      cmd = tt_pkg::CMD_TICK;
      else if (roll < 89)      cmd = tt_pkg::CMD_HEARD;
      else if (roll < 94)      cmd = tt_pkg::CMD_START;
      else if (roll < 97)      cmd = CMD_SPARE;
      else                     cmd = tt_pkg::CMD_TICK;
      roll = int'($urandom_range(9));
      if (roll == 0)      frac = '0;
      else if (roll == 1) frac = FRAC_ALL_ONES;
      else                frac = rand_frac();
      send_cmd(cmd, frac);
    end
  endtask

  // Four idle mixes: none, sender mostly idle, receiver mostly stalled, both
  // some. Each drain between streams is a full sender pause.
  task automatic test_random();
    int idle_mix[4]  = '{0, 87, 0, 26};
    int stall_mix[4] = '{0, 0, 87, 26};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      for (int s = 0; s < 2; s++) begin
        drain();
        random_config();
        run_stream(45);
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.command         = tt_pkg::CMD_TICK;
    in_ch.random_fraction = '0;
    timer_clear();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_stopped();
    test_small_min();
    test_fire_extremes();
    test_doubling_limit();
    test_heard_saturation();
    test_random();
    drain();

    $display("Covered %0d commands: stopped timer, small and large minimum, doubling limits,",
             n_sent);
    $display("  heard saturation, %0d transmits, %0d suppressions, %0d new intervals",
             n_tx, n_sup, n_new);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
